@@ rtl/pglr_pkg.sv @@
// shared constants, control types and register indexes of the gain and resampler block
package pglr_pkg;

	// fixed-point formats
	localparam int FRAC_BITS      = 16;
	localparam int GAIN_FRAC_BITS = 24;

	// field widths
	localparam int SAMPLE_W  = 32;
	localparam int SBITS_W   = 6;
	localparam int GAIN_W    = 40;
	localparam int GAIN_HI_W = GAIN_W - 32;
	localparam int STEP_W    = 20;
	localparam int PHASE_W   = 21;

	// gain product widths
	localparam int GPROD_W = 64;
	localparam int GHI_W   = SAMPLE_W + GAIN_HI_W;
	localparam int GQ_W    = GHI_W + 32 - GAIN_FRAC_BITS;

	// interpolation widths
	localparam int DIFF_W  = SAMPLE_W + 1;
	localparam int WGT_W   = FRAC_BITS + 1;
	localparam int IPROD_W = DIFF_W + WGT_W;

	// phase constants
	localparam logic [PHASE_W-1:0] PH_ONE   = PHASE_W'(1 << FRAC_BITS);
	localparam logic [PHASE_W-1:0] PH_TWO   = PHASE_W'(2 << FRAC_BITS);
	localparam logic [PHASE_W-1:0] MIN_STEP = PHASE_W'((1 << FRAC_BITS) >> 5);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_STEP   = 2'd3;
	localparam int CFG_DATA_W = GAIN_W;

	// controller to datapath commands
	typedef struct packed {
		logic load_raw;
		logic chan;
		logic gain_lo;
		logic gain_hi;
		logic gain_done;
		logic issue;
		logic seg;
		logic fin;
		logic wrap;
		logic commit;
	} pglr_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic held_valid;
		logic ph_lt_one;
		logic adv;
	} pglr_status_t;

endpackage

@@ rtl/pglr_ctrl.sv @@
// controller state machine: gain sequencing, interval runs and frame commit
module pglr_ctrl import pglr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic         final_frame,
	input  logic         stereo_mode,
	input  pglr_status_t st,
	output logic         in_stall,
	output pglr_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_GLO   = 3'd1;
	localparam logic [2:0] ST_GHI   = 3'd2;
	localparam logic [2:0] ST_GCMB  = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_STORE = 3'd5;

	logic [2:0] state_q, state_d;
	logic       chan_q, chan_d;
	logic       seg_q, seg_d;
	logic       fin_q, fin_d;

	// next state and command decode
	always_comb begin
		state_d       = state_q;
		chan_d        = chan_q;
		seg_d         = seg_q;
		fin_d         = fin_q;
		cmd           = '0;
		cmd.chan      = chan_q;
		cmd.seg       = seg_q;
		cmd.fin       = fin_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load_raw = in_valid;
				if (in_valid) begin
					fin_d   = final_frame;
					chan_d  = 1'b0;
					state_d = ST_GLO;
				end
			end
			ST_GLO: begin
				cmd.gain_lo = 1'b1;
				state_d     = ST_GHI;
			end
			ST_GHI: begin
				cmd.gain_hi = 1'b1;
				state_d     = ST_GCMB;
			end
			ST_GCMB: begin
				cmd.gain_done = 1'b1;
				if (!chan_q && stereo_mode) begin
					chan_d  = 1'b1;
					state_d = ST_GLO;
				end else if (st.held_valid) begin
					seg_d   = 1'b0;
					state_d = ST_RUN;
				end else if (fin_q) begin
					seg_d   = 1'b1;
					state_d = ST_RUN;
				end else begin
					state_d = ST_STORE;
				end
			end
			ST_RUN: begin
				if (st.ph_lt_one) begin
					cmd.issue = st.adv;
				end else begin
					cmd.wrap = 1'b1;
					if (!seg_q && fin_q) begin
						seg_d = 1'b1;
					end else begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			ST_STORE: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chan_q  <= 1'b0;
			seg_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			chan_q  <= chan_d;
			seg_q   <= seg_d;
			fin_q   <= fin_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

@@ rtl/pglr_dp.sv @@
// datapath: sign extension, gain multiply and saturation, held frame, phase, interpolation pipeline
module pglr_dp import pglr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pglr_cmd_t             cmd,
	input  logic [SBITS_W-1:0]    sample_bits,
	input  logic                  stereo_mode,
	input  logic [GAIN_W-1:0]     gain_q24,
	input  logic [STEP_W-1:0]     rate_step_q16,
	input  logic [SAMPLE_W-1:0]   left_raw,
	input  logic [SAMPLE_W-1:0]   right_raw,
	input  logic                  out_stall,
	output pglr_status_t          st,
	output logic                  out_valid,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out,
	output logic                  run_end,
	output logic                  track_end
);

	localparam logic [GQ_W-1:0] POS_MAX = GQ_W'(32'h7fff_ffff);
	localparam logic [GQ_W-1:0] NEG_MAX = GQ_W'(32'h8000_0000);

	// sign extension from the configured byte count
	function automatic logic [SAMPLE_W-1:0] extend_raw(input logic [SAMPLE_W-1:0] raw,
			input logic [SBITS_W-1:0] sbits);
		logic [2:0]          nb;
		logic [SAMPLE_W-1:0] v;
		nb = sbits[SBITS_W-1:3];
		case (nb) inside
			[3'd0:3'd1]: v = {{24{raw[7]}}, raw[7:0]};
			3'd2:        v = {{16{raw[15]}}, raw[15:0]};
			3'd3:        v = {{8{raw[23]}}, raw[23:0]};
			default:     v = raw;
		endcase
		return v;
	endfunction

	// numerator scaled down by one phase unit, truncated toward zero
	function automatic logic [SAMPLE_W-1:0] trunc_frac(input logic [IPROD_W-1:0] n);
		logic [SAMPLE_W-1:0] q;
		q = n[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
		if (n[IPROD_W-1] && (|n[FRAC_BITS-1:0])) begin
			q = q + 32'd1;
		end
		return q;
	endfunction

	logic [SAMPLE_W-1:0] raw_l_q, raw_r_q;
	logic [SAMPLE_W-1:0] g_raw, g_s, g_mag, g_opnd, g_res;
	logic                g_neg;
	logic [GPROD_W-1:0]  g_prod;
	logic [GPROD_W-1:0]  plo_q;
	logic [GHI_W-1:0]    phi_q;
	logic [GQ_W-1:0]     g_q;

	logic [SAMPLE_W-1:0] new_l_q, new_r_q, held_l_q, held_r_q;
	logic                held_valid_q;
	logic [PHASE_W-1:0]  phase_q, step_eff, ph_next;
	logic                iss_last, iss_run;

	logic [SAMPLE_W-1:0]       a_l, a_r, b_l, b_r;
	logic signed [DIFF_W-1:0]  d_l, d_r;
	logic signed [WGT_W-1:0]   wgt;
	logic signed [IPROD_W-1:0] p_l, p_r;

	logic                      v_s1, run_s1, trk_s1;
	logic [SAMPLE_W-1:0]       a_l_s1, a_r_s1;
	logic signed [IPROD_W-1:0] p_l_s1, p_r_s1;
	logic [IPROD_W-1:0]        n_l, n_r;
	logic                      adv;

	logic                out_valid_q, run_q, trk_q;
	logic [SAMPLE_W-1:0] left_q, right_q;

	// input frame capture
	always_ff @(posedge clk) begin
		if (cmd.load_raw) begin
			raw_l_q <= left_raw;
			raw_r_q <= right_raw;
		end
	end

	// shared gain multiplier, low then high gain word
	assign g_raw  = cmd.chan ? raw_r_q : raw_l_q;
	assign g_s    = extend_raw(g_raw, sample_bits);
	assign g_neg  = g_s[SAMPLE_W-1];
	assign g_mag  = g_neg ? (32'd0 - g_s) : g_s;
	assign g_opnd = cmd.gain_hi ? {{(32-GAIN_HI_W){1'b0}}, gain_q24[GAIN_W-1:32]}
		: gain_q24[31:0];
	assign g_prod = {32'd0, g_mag} * {32'd0, g_opnd};

	always_ff @(posedge clk) begin
		if (cmd.gain_lo) begin
			plo_q <= g_prod;
		end
		if (cmd.gain_hi) begin
			phi_q <= g_prod[GHI_W-1:0];
		end
	end

	// partial product sum and saturation to 32 bits
	assign g_q = (GQ_W'(phi_q) << (32 - GAIN_FRAC_BITS)) + GQ_W'(plo_q >> GAIN_FRAC_BITS);

	always_comb begin
		if (g_neg) begin
			g_res = (g_q > NEG_MAX) ? 32'h8000_0000 : (32'd0 - g_q[31:0]);
		end else begin
			g_res = (g_q > POS_MAX) ? 32'h7fff_ffff : g_q[31:0];
		end
	end

	// scaled new frame, mono copies left into right
	always_ff @(posedge clk) begin
		if (cmd.gain_done) begin
			if (!cmd.chan) begin
				new_l_q <= g_res;
				if (!stereo_mode) begin
					new_r_q <= g_res;
				end
			end else begin
				new_r_q <= g_res;
			end
		end
	end

	// held frame, cleared after a final frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_l_q     <= '0;
			held_r_q     <= '0;
			held_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			if (cmd.fin) begin
				held_l_q     <= '0;
				held_r_q     <= '0;
				held_valid_q <= 1'b0;
			end else begin
				held_l_q     <= new_l_q;
				held_r_q     <= new_r_q;
				held_valid_q <= 1'b1;
			end
		end
	end

	// phase accumulator
	assign step_eff = (PHASE_W'(rate_step_q16) < MIN_STEP) ? MIN_STEP : PHASE_W'(rate_step_q16);
	assign ph_next  = phase_q + step_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (cmd.commit && cmd.fin) begin
			phase_q <= '0;
		end else if (cmd.wrap) begin
			phase_q <= phase_q - PH_ONE;
		end else if (cmd.issue) begin
			phase_q <= ph_next;
		end
	end

	// end-of-run flags: a final frame whose flush interval is empty ends on its first interval
	assign iss_last = (ph_next >= PH_ONE);
	assign iss_run  = iss_last && (cmd.seg || !cmd.fin || (ph_next >= PH_TWO));

	// interval endpoints and weighted difference
	assign a_l = cmd.seg ? new_l_q : held_l_q;
	assign a_r = cmd.seg ? new_r_q : held_r_q;
	assign b_l = cmd.seg ? '0 : new_l_q;
	assign b_r = cmd.seg ? '0 : new_r_q;
	assign d_l = $signed({b_l[SAMPLE_W-1], b_l}) - $signed({a_l[SAMPLE_W-1], a_l});
	assign d_r = $signed({b_r[SAMPLE_W-1], b_r}) - $signed({a_r[SAMPLE_W-1], a_r});
	assign wgt = $signed({1'b0, phase_q[FRAC_BITS-1:0]});
	assign p_l = d_l * wgt;
	assign p_r = d_r * wgt;

	assign adv = !out_valid_q || !out_stall;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cmd.issue) begin
			a_l_s1 <= a_l;
			a_r_s1 <= a_r;
			p_l_s1 <= p_l;
			p_r_s1 <= p_r;
			run_s1 <= iss_run;
			trk_s1 <= iss_run && cmd.fin;
		end
	end

	// numerator add and truncation into the output register
	assign n_l = {{(IPROD_W-SAMPLE_W-FRAC_BITS){a_l_s1[SAMPLE_W-1]}}, a_l_s1,
		{FRAC_BITS{1'b0}}} + p_l_s1;
	assign n_r = {{(IPROD_W-SAMPLE_W-FRAC_BITS){a_r_s1[SAMPLE_W-1]}}, a_r_s1,
		{FRAC_BITS{1'b0}}} + p_r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			left_q  <= trunc_frac(n_l);
			right_q <= trunc_frac(n_r);
			run_q   <= run_s1;
			trk_q   <= trk_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = $signed(left_q);
	assign right_out = $signed(right_q);
	assign run_end   = run_q;
	assign track_end = trk_q;

	assign st.held_valid = held_valid_q;
	assign st.ph_lt_one  = (phase_q < PH_ONE);
	assign st.adv        = adv;

endmodule

@@ rtl/pcm_gain_linear_resampler_top.sv @@
// top level: configuration registers, controller and datapath
// Gain stage and linear-interpolation rate converter for mono or stereo PCM frames. A frame
// is taken while the block is idle, then each channel is scaled on one shared 32x32
// multiplier: low gain word, then high gain word, then sum and saturation. Each interval
// then gives one result per cycle while the output does not stall, and is then closed;
// an item gives n results (up to 32 per interval, 64 for a final frame) and closes one or
// two intervals, or none for a first frame that is only stored. Results leave through a
// two-stage product and output pipeline; an output stall holds the pipeline and pauses
// result issue. A final frame flushes against silence and returns the held frame and the
// phase to their reset state. cfg_ready is always high; the user must write registers only
// while the block is idle, and the block itself does not enforce this.
module pcm_gain_linear_resampler_top import pglr_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SAMPLE_W-1:0]        left_raw,
	input  logic [SAMPLE_W-1:0]        right_raw,
	input  logic                       final_frame,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out,
	output logic                       run_end,
	output logic                       track_end
);

	logic [SBITS_W-1:0] sample_bits_q;
	logic               stereo_mode_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [STEP_W-1:0]  rate_step_q;
	pglr_cmd_t          cmd;
	pglr_status_t       st;

	assign cfg_ready = 1'b1;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bits_q <= SBITS_W'(16);
			stereo_mode_q <= 1'b1;
			gain_q        <= GAIN_W'(1) << GAIN_FRAC_BITS;
			rate_step_q   <= STEP_W'(1) << FRAC_BITS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SAMPLE_BITS: sample_bits_q <= cfg_data[SBITS_W-1:0];
				REG_STEREO_MODE: stereo_mode_q <= cfg_data[0];
				REG_GAIN:        gain_q        <= cfg_data[GAIN_W-1:0];
				REG_RATE_STEP:   rate_step_q   <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// controller
	pglr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.final_frame (final_frame),
		.stereo_mode (stereo_mode_q),
		.st          (st),
		.in_stall    (in_stall),
		.cmd         (cmd)
	);

	// datapath
	pglr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sample_bits   (sample_bits_q),
		.stereo_mode   (stereo_mode_q),
		.gain_q24      (gain_q),
		.rate_step_q16 (rate_step_q),
		.left_raw      (left_raw),
		.right_raw     (right_raw),
		.out_stall     (out_stall),
		.st            (st),
		.out_valid     (out_valid),
		.left_out      (left_out),
		.right_out     (right_out),
		.run_end       (run_end),
		.track_end     (track_end)
	);

	// track end only ever marks the last result of a run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!track_end || run_end))
		else $error("track_end without run_end");

	// a result is issued only when the pipeline can advance
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> st.adv)
		else $error("result issued into a stalled pipeline");

	// one frame at a time: input stalls right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after transfer");

	// a final frame leaves no frame held
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && cmd.fin) |=> !st.held_valid)
		else $error("frame still held after flush");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the pcm gain and linear-interpolation resampler
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pglr_pkg::*;

	localparam int          CLK_PERIOD  = 4;
	localparam int          RESET_CYC   = 11;
	localparam int          IDLE_WAIT   = 96;
	localparam int          CYCLE_LIMIT = 2_000_000;
	localparam int          MAX_SHOWN   = 10;
	localparam int          NUM_PHASES  = 8;
	localparam int          PHASE_ITEMS = 40;
	localparam int unsigned PHASE_ONE   = 1 << FRAC_BITS;
	localparam int unsigned STEP_FLOOR  = PHASE_ONE >> 5;
	localparam logic [SAMPLE_W-1:0] NA  = '0;

	// one interpolated output frame
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       run_end;
		logic                       track_end;
	} interp_result_t;

	typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

	// directed stimulus row: a register write or a frame, optionally with typed results
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [SAMPLE_W-1:0]   left;
		logic [SAMPLE_W-1:0]   right;
		logic                  fin;
		logic                  typed;
		logic [1:0]            nres;
		logic [SAMPLE_W-1:0]   l0;
		logic [SAMPLE_W-1:0]   r0;
		logic [SAMPLE_W-1:0]   l1;
		logic [SAMPLE_W-1:0]   r1;
	} stim_row_t;

	localparam int NUM_ROWS = 37;
	localparam stim_row_t DIRECTED [NUM_ROWS] = '{
		// reset settings: 16-bit stereo, unity gain, unity step
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'hABCD1234, 32'h00008000, 1'b0, 1'b1, 2'd0,
			NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00008000, 32'hFFFF7FFF, 1'b0, 1'b1, 2'd1,
			32'h00001234, 32'hFFFF8000, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b1, 2'd2,
			32'hFFFF8000, 32'h00007FFF, 32'hFFFFFFFF, 32'h00000000},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00007FFF, 32'h12340001, 1'b1, 1'b1, 2'd1,
			32'h00007FFF, 32'h00000001, NA, NA},
		// full-scale gain saturates both ways
		'{ROW_CFG, REG_SAMPLE_BITS, 40'd32, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_CFG, REG_GAIN, 40'hFF_FFFF_FFFF, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1, 2'd1,
			32'h7FFFFFFF, 32'h80000000, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00000001, 32'hFFFFFFFF, 1'b1, 1'b1, 2'd1,
			32'h0000FFFF, 32'hFFFF0001, NA, NA},
		'{ROW_CFG, REG_GAIN, 40'h0, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b1, 2'd1,
			32'h00000000, 32'h00000000, NA, NA},
		// mono copies left into right
		'{ROW_CFG, REG_GAIN, 40'h00_0100_0000, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_CFG, REG_SAMPLE_BITS, 40'd8, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_CFG, REG_STEREO_MODE, 40'd0, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00000180, 32'h0000007F, 1'b1, 1'b1, 2'd1,
			32'hFFFFFF80, 32'hFFFFFF80, NA, NA},
		'{ROW_CFG, REG_STEREO_MODE, 40'd1, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_CFG, REG_SAMPLE_BITS, 40'd24, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00800000, 32'hFF7FFFFF, 1'b1, 1'b1, 2'd1,
			32'hFF800000, 32'h007FFFFF, NA, NA},
		// odd widths clamp to one to four bytes
		'{ROW_CFG, REG_SAMPLE_BITS, 40'd0, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h000000FF, 32'h12345601, 1'b1, 1'b1, 2'd1,
			32'hFFFFFFFF, 32'h00000001, NA, NA},
		'{ROW_CFG, REG_SAMPLE_BITS, 40'd63, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h80000000, 32'h00000005, 1'b1, 1'b1, 2'd1,
			32'h80000000, 32'h00000005, NA, NA},
		'{ROW_CFG, REG_SAMPLE_BITS, 40'd12, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00000F80, 32'h0000007F, 1'b1, 1'b1, 2'd1,
			32'hFFFFFF80, 32'h0000007F, NA, NA},
		// zero step runs at the slowest step, final frame gives the most results
		'{ROW_CFG, REG_SAMPLE_BITS, 40'd16, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_CFG, REG_RATE_STEP, 40'd0, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00004000, 32'hFFFFC000, 1'b0, 1'b0, 2'd0,
			NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'hFFFF8000, 32'h00007FFF, 1'b1, 1'b0, 2'd0,
			NA, NA, NA, NA},
		// largest step: long silent stretches and an empty final run
		'{ROW_CFG, REG_RATE_STEP, 40'hFFFFF, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00001111, 32'h00002222, 1'b0, 1'b0, 2'd0,
			NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00007FFF, 32'h00008000, 1'b0, 1'b0, 2'd0,
			NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00000100, 32'h00000200, 1'b0, 1'b0, 2'd0,
			NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00000300, 32'h00000400, 1'b1, 1'b0, 2'd0,
			NA, NA, NA, NA},
		// fractional step with gain above one
		'{ROW_CFG, REG_RATE_STEP, 40'h18000, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_CFG, REG_GAIN, 40'h00_0280_0000, NA, NA, 1'b0, 1'b0, 2'd0, NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00001000, 32'h0000F000, 1'b0, 1'b0, 2'd0,
			NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00007000, 32'h00009000, 1'b0, 1'b0, 2'd0,
			NA, NA, NA, NA},
		'{ROW_FRAME, REG_SAMPLE_BITS, 40'h0, 32'h00000010, 32'h0000FFF0, 1'b1, 1'b0, 2'd0,
			NA, NA, NA, NA}
	};

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [SAMPLE_W-1:0]        left_raw;
	logic [SAMPLE_W-1:0]        right_raw;
	logic                       final_frame;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic                       run_end;
	logic                       track_end;

	// register mirror and resampler state of the predictor
	logic [SBITS_W-1:0]         cfg_bits;
	logic                       cfg_stereo;
	logic [GAIN_W-1:0]          cfg_gain;
	logic [STEP_W-1:0]          cfg_step;
	logic signed [SAMPLE_W-1:0] hold_l;
	logic signed [SAMPLE_W-1:0] hold_r;
	logic                       hold_ok;
	int unsigned                phase_acc;

	interp_result_t frame_out[$];
	interp_result_t interp_queue[$];

	int  mismatch_cnt = 0;
	int  results_seen = 0;
	int  frames_sent  = 0;
	int  reg_writes   = 0;
	int  drains       = 0;
	int  burst_left   = 0;
	int  cycle_cnt    = 0;
	bit  busy         = 1'b0;

	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	logic [7:0]  stall_mask = 8'h0;

	pcm_gain_linear_resampler_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.left_raw   (left_raw),
		.right_raw  (right_raw),
		.final_frame(final_frame),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.left_out   (left_out),
		.right_out  (right_out),
		.run_end    (run_end),
		.track_end  (track_end)
	);

	always #(CLK_PERIOD / 2.0) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				interp_queue.size());
			$display("testbench failed");
			$finish;
		end
	end

	// output backpressure: free, light, heavy or a rotating mask, switched now and then
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(32, 256);
			stall_mask <= 8'($urandom());
		end else begin
			stall_left <= stall_left - 1;
			if (stall_mode == STALL_PATTERN)
				stall_mask <= {stall_mask[0], stall_mask[7:1]};
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_mask[0];
		endcase
	end

	// compare each output transfer with the oldest expected frame
	always @(posedge clk) begin
		interp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (interp_queue.size() == 0) begin
				mismatch_cnt <= mismatch_cnt + 1;
				if (mismatch_cnt < MAX_SHOWN)
					$display("unexpected result at cycle %0d: l=%h r=%h run_end=%b track_end=%b",
						cycle_cnt, left_out, right_out, run_end, track_end);
			end else begin
				want = interp_queue.pop_front();
				if (left_out !== want.left || right_out !== want.right ||
						run_end !== want.run_end || track_end !== want.track_end) begin
					mismatch_cnt <= mismatch_cnt + 1;
					if (mismatch_cnt < MAX_SHOWN)
						$display("result %0d mismatch: expected l=%h r=%h run_end=%b track_end=%b, %s",
							results_seen, want.left, want.right, want.run_end, want.track_end,
							$sformatf("got l=%h r=%h run_end=%b track_end=%b",
								left_out, right_out, run_end, track_end));
				end
			end
		end
	end

	// sign-extend from the configured width, apply gain, truncate and saturate
	function automatic logic signed [SAMPLE_W-1:0] scale_raw(input logic [SAMPLE_W-1:0] raw);
		int unsigned                nbytes;
		int unsigned                sh;
		logic signed [SAMPLE_W-1:0] s;
		longint                     sl;
		logic [79:0]                prod;
		nbytes = cfg_bits >> 3;
		if (nbytes < 1) nbytes = 1;
		if (nbytes > 4) nbytes = 4;
		sh = 32 - 8 * nbytes;
		s = $signed(raw << sh) >>> sh;
		sl = s;
		prod = 80'(sl < 0 ? -sl : sl) * 80'(cfg_gain);
		prod = prod >> GAIN_FRAC_BITS;
		if (sl < 0)
			return (prod > 80'h8000_0000) ? 32'sh8000_0000 : SAMPLE_W'(-prod[31:0]);
		return (prod > 80'h7FFF_FFFF) ? 32'sh7FFF_FFFF : prod[31:0];
	endfunction

	// walk the phase across one interval from frame a to frame b
	function automatic void close_interval(input longint al, input longint ar,
			input longint bl, input longint br);
		longint         f;
		longint         w;
		int unsigned    stp;
		interp_result_t res;
		stp = (cfg_step < STEP_FLOOR) ? STEP_FLOOR : cfg_step;
		while (phase_acc < PHASE_ONE) begin
			f = phase_acc;
			w = longint'(PHASE_ONE) - f;
			res.left      = SAMPLE_W'((al * w + bl * f) / longint'(PHASE_ONE));
			res.right     = SAMPLE_W'((ar * w + br * f) / longint'(PHASE_ONE));
			res.run_end   = 1'b0;
			res.track_end = 1'b0;
			frame_out.insert(frame_out.size(), res);
			phase_acc += stp;
		end
		phase_acc -= PHASE_ONE;
	endfunction

	// resampled frames caused by one input frame, left in frame_out
	function automatic void resample_frame(input logic [SAMPLE_W-1:0] l,
			input logic [SAMPLE_W-1:0] r, input logic fin);
		logic signed [SAMPLE_W-1:0] nl;
		logic signed [SAMPLE_W-1:0] nr;
		nl = scale_raw(l);
		nr = cfg_stereo ? scale_raw(r) : nl;
		frame_out.delete();
		if (hold_ok) close_interval(hold_l, hold_r, nl, nr);
		hold_l  = nl;
		hold_r  = nr;
		hold_ok = 1'b1;
		if (fin) begin
			close_interval(nl, nr, 0, 0);
			hold_l    = '0;
			hold_r    = '0;
			hold_ok   = 1'b0;
			phase_acc = 0;
		end
		if (frame_out.size() > 0) begin
			frame_out[frame_out.size() - 1].run_end   = 1'b1;
			frame_out[frame_out.size() - 1].track_end = fin;
		end
	endfunction

	// random sample: mostly full-width noise, sometimes width extremes or small values
	function automatic logic [SAMPLE_W-1:0] pick_raw();
		logic [SAMPLE_W-1:0] junk;
		logic [SAMPLE_W-1:0] mask;
		int unsigned         nbytes;
		junk = $urandom();
		nbytes = cfg_bits >> 3;
		if (nbytes < 1) nbytes = 1;
		if (nbytes > 4) nbytes = 4;
		mask = 32'hFFFF_FFFF >> (32 - 8 * nbytes);
		case ($urandom_range(0, 11))
			0: return (junk & ~mask) | (mask >> 1);
			1: return (junk & ~mask) | (mask & ~(mask >> 1));
			2: return junk & ~mask;
			3: return junk | mask;
			4: return (junk & ~mask) | SAMPLE_W'($urandom_range(0, 15));
			default: return junk;
		endcase
	endfunction

	// append one expected result to the scoreboard
	function automatic void queue_expected(input interp_result_t r);
		interp_queue.insert(interp_queue.size(), r);
	endfunction

	// offer one frame and wait for its transfer; valid stays high for the caller
	task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
			input logic fin, input bit predicted);
		in_valid    <= 1'b1;
		left_raw    <= l;
		right_raw   <= r;
		final_frame <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		resample_frame(l, r, fin);
		if (predicted)
			foreach (frame_out[i]) queue_expected(frame_out[i]);
		frames_sent++;
		busy = 1'b1;
	endtask

	// burst bookkeeping: random gaps, and now and then wait until all results are out
	task automatic sender_gap();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 15);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		if (drains == 0 || $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (interp_queue.size() != 0);
			drains++;
		end else if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drain and let the block finish frames that give no result
	task automatic settle_idle();
		if (!busy) return;
		in_valid <= 1'b0;
		do @(posedge clk); while (interp_queue.size() != 0);
		repeat (IDLE_WAIT) @(posedge clk);
		busy = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SAMPLE_BITS: cfg_bits   = val[SBITS_W-1:0];
			REG_STEREO_MODE: cfg_stereo = val[0];
			REG_GAIN:        cfg_gain   = val[GAIN_W-1:0];
			default:         cfg_step   = val[STEP_W-1:0];
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// stimulus: directed table, then random recordings over several settings
	initial begin : main
		stim_row_t             row;
		interp_result_t        res;
		logic                  fin;
		logic [CFG_DATA_W-1:0] bits_val;
		logic [CFG_DATA_W-1:0] gain_val;
		logic [CFG_DATA_W-1:0] step_val;
		int                    sent;
		int                    len;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		left_raw    = '0;
		right_raw   = '0;
		final_frame = 1'b0;
		cfg_bits    = 6'd16;
		cfg_stereo  = 1'b1;
		cfg_gain    = GAIN_W'(1) << GAIN_FRAC_BITS;
		cfg_step    = STEP_W'(PHASE_ONE);
		hold_l      = '0;
		hold_r      = '0;
		hold_ok     = 1'b0;
		phase_acc   = 0;
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG) begin
				settle_idle();
				write_reg(row.idx, row.data);
			end else begin
				send_frame(row.left, row.right, row.fin, !row.typed);
				if (row.typed) begin
					for (int k = 0; k < row.nres; k++) begin
						res.left      = (k == 0) ? row.l0 : row.l1;
						res.right     = (k == 0) ? row.r0 : row.r1;
						res.run_end   = (k == row.nres - 1);
						res.track_end = (k == row.nres - 1) && row.fin;
						queue_expected(res);
					end
				end
				sender_gap();
			end
		end

		// random phases, each under its own register settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			bits_val = (p == 5) ? CFG_DATA_W'($urandom_range(0, 63)) : CFG_DATA_W'(8 * (1 + p % 4));
			case (p)
				2:       gain_val = 40'hFF_FFFF_FFFF;
				4:       gain_val = CFG_DATA_W'({8'($urandom_range(0, 255)), 32'($urandom())});
				default: gain_val = CFG_DATA_W'($urandom_range(32'h0040_0000, 32'h0400_0000));
			endcase
			case (p)
				0:       step_val = CFG_DATA_W'(STEP_FLOOR);
				1:       step_val = 40'hFFFFF;
				3:       step_val = CFG_DATA_W'(PHASE_ONE);
				7:       step_val = CFG_DATA_W'($urandom_range(0, STEP_FLOOR - 1));
				default: step_val = ($urandom_range(0, 1) == 0) ?
						CFG_DATA_W'($urandom_range(STEP_FLOOR, PHASE_ONE)) :
						CFG_DATA_W'($urandom_range(PHASE_ONE, 300000));
			endcase
			settle_idle();
			write_reg(REG_SAMPLE_BITS, bits_val);
			write_reg(REG_STEREO_MODE, CFG_DATA_W'(p % 3 != 1));
			write_reg(REG_GAIN, gain_val);
			write_reg(REG_RATE_STEP, step_val);

			// recordings of random length, mostly closed by a final frame
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = $urandom_range(1, 10);
				for (int k = 0; k < len; k++) begin
					if (k == len - 1)
						fin = ($urandom_range(0, 9) != 0);
					else
						fin = ($urandom_range(0, 19) == 0);
					send_frame(pick_raw(), pick_raw(), fin, 1'b1);
					sent++;
					sender_gap();
				end
			end
		end

		// drain and let the pipeline run dry
		in_valid <= 1'b0;
		do @(posedge clk); while (interp_queue.size() != 0);
		repeat (IDLE_WAIT) @(posedge clk);

		$display("%0d frames sent (%0d directed rows) under %0d register writes, %0d drains",
			frames_sent, NUM_ROWS, reg_writes, drains);
		$display("%0d resampled frames checked, %0d mismatches", results_seen, mismatch_cnt);
		if (mismatch_cnt == 0 && interp_queue.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
